[rtl/lwsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lwsd_pkg
// Shared constants and types of the local window standard deviation filter.
// ----------------------------------------------------------------------------
package lwsd_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HALF  = 7;

	// square root: 16-bit radicand, 8-bit root
	localparam int RAD_W  = 16;
	localparam int ROOT_W = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_FLUSH,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV,
		ST_ROOT,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [RAD_W-1:0]  radicand;
		logic [ROOT_W-1:0] root;
	} sqrt_bus_t;

endpackage
`default_nettype wire

[rtl/local_window_std_deviation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// local_window_std_deviation
// Standard deviation over a clipped window around each pixel of a raster frame.
// ----------------------------------------------------------------------------
// An item without result leaves the block idle; an item with result runs ACC,
// FLUSH, MUL, DIV_GO, DIV, ROOT and SEND, and no new item is taken until it is
// sent. The window is read from the line store one pixel per cycle and the
// divider takes one quotient bit per cycle.
// Reset (arst_n low, asynchronous): registers back to width 1024, height 1,
// half sizes 1; position counters cleared; the line store is not cleared.
// ----------------------------------------------------------------------------
module local_window_std_deviation #(
	parameter int MaxWidth = lwsd_pkg::MAX_WIDTH,
	parameter int MaxHalf  = lwsd_pkg::MAX_HALF
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_write,
	input  wire [1:0]  cfg_index,
	input  wire [15:0] cfg_data,
	// input items
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        kind,
	input  wire [7:0]  pixel,
	// result items
	output logic       out_valid,
	input  wire        out_ready,
	output logic [6:0] deviation,
	output logic       frame_end
);
	localparam int Win     = 2 * MaxHalf + 1;
	localparam int WinArea = Win * Win;
	localparam int Ring    = 2 * MaxHalf + 2;
	localparam int CW      = $clog2(MaxWidth);
	localparam int WW      = $clog2(MaxWidth + 1);
	localparam int HW      = $clog2(MaxHalf + 1);
	localparam int RW      = $clog2(Ring);
	localparam int AW      = $clog2(Ring * MaxWidth);
	localparam int DW      = $clog2(MaxHalf + MaxHalf * MaxWidth + 1);
	localparam int NW      = $clog2(WinArea + 1);
	localparam int SW      = $clog2(WinArea * 255 + 1);
	localparam int QW      = $clog2(WinArea * 65025 + 1);
	localparam int NumW    = NW + QW;
	localparam int DenW    = 2 * NW;
	localparam int XW      = CW + HW;
	localparam int YW      = 16 + HW;
	localparam int RtW     = lwsd_pkg::ROOT_W;
	localparam int RdW     = lwsd_pkg::RAD_W;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HALF_X = 2'd2;
	localparam logic [1:0] REG_HALF_Y = 2'd3;

	// configuration registers
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  half_x_q;
	logic [2:0]  half_y_q;

	// effective geometry
	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	logic [HW-1:0] hx;
	logic [HW-1:0] hy;
	logic [DW-1:0] delay;
	logic [CW-1:0] w_last;
	logic [15:0]   h_last;

	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MaxWidth) begin
			w_eff = WW'(MaxWidth);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff  = (height_q == 16'd0) ? 16'd1 : height_q;
		hx     = (32'(half_x_q) > MaxHalf) ? HW'(MaxHalf) : HW'(half_x_q);
		hy     = (32'(half_y_q) > MaxHalf) ? HW'(MaxHalf) : HW'(half_y_q);
		delay  = DW'(hx) + DW'(DW'(hy) * DW'(w_eff));
		w_last = CW'(w_eff - WW'(1));
		h_last = h_eff - 16'd1;
	end

	// position counters: write side, early-item count, result side
	logic [CW-1:0] in_col_q;
	logic [15:0]   in_row_q;
	logic [RW-1:0] in_ring_q;
	logic          in_done_q;
	logic [DW-1:0] pre_q;
	logic [CW-1:0] out_col_q;
	logic [15:0]   out_row_q;
	logic [RW-1:0] out_ring_q;

	lwsd_pkg::state_t state_q, state_d;

	logic accept;
	logic emit;
	logic fe;

	assign in_ready = (state_q == lwsd_pkg::ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign emit     = (pre_q == delay);
	assign fe       = (out_row_q == h_last) && (out_col_q == w_last);

	// clipped window around the next result position
	logic [CW-1:0] c0, c1;
	logic [15:0]   r0, r1;
	logic [RW-1:0] ring0;
	logic [RW-1:0] rdist;
	logic [XW-1:0] xsum;
	logic [YW-1:0] ysum;

	always_comb begin
		c0    = (XW'(out_col_q) >= XW'(hx)) ? CW'(XW'(out_col_q) - XW'(hx)) : '0;
		xsum  = XW'(out_col_q) + XW'(hx);
		c1    = (xsum > XW'(w_last)) ? w_last : CW'(xsum);
		r0    = (out_row_q >= 16'(hy)) ? out_row_q - 16'(hy) : 16'd0;
		ysum  = YW'(out_row_q) + YW'(hy);
		r1    = (ysum > YW'(h_last)) ? h_last : ysum[15:0];
		rdist = RW'(out_row_q - r0);
		ring0 = (out_ring_q >= rdist) ? out_ring_q - rdist
		                              : out_ring_q + RW'(Ring) - rdist;
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 11'd1024;
			height_q   <= 16'd1;
			half_x_q   <= 3'd1;
			half_y_q   <= 3'd1;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ring_q  <= '0;
			in_done_q  <= 1'b0;
			pre_q      <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ring_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_HALF_X: half_x_q <= cfg_data[2:0];
				REG_HALF_Y: half_y_q <= cfg_data[2:0];
				default: ;
			endcase
			// any write restarts the frame
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ring_q  <= '0;
			in_done_q  <= 1'b0;
			pre_q      <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ring_q <= '0;
		end else if (accept) begin
			if (!in_done_q) begin
				if (in_col_q == w_last) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 16'd1;
					in_ring_q <= (in_ring_q == RW'(Ring - 1)) ? '0 : in_ring_q + RW'(1);
					if (in_row_q == h_last) begin
						in_done_q <= 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (!emit) begin
				pre_q <= pre_q + DW'(1);
			end else if (fe) begin
				// last result of the frame: next item opens a new frame
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_ring_q  <= '0;
				in_done_q  <= 1'b0;
				pre_q      <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_ring_q <= '0;
			end else if (out_col_q == w_last) begin
				out_col_q  <= '0;
				out_row_q  <= out_row_q + 16'd1;
				out_ring_q <= (out_ring_q == RW'(Ring - 1)) ? '0 : out_ring_q + RW'(1);
			end else begin
				out_col_q <= out_col_q + CW'(1);
			end
		end
	end

	// line store: Ring lines of MaxWidth pixels, one write and one read port
	logic [7:0]    store [Ring * MaxWidth];
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_s1;
	logic          rd_valid_s1;

	// window walk
	logic [CW-1:0] cur_col_q;
	logic [15:0]   cur_row_q;
	logic [RW-1:0] cur_ring_q;
	logic [CW-1:0] c0_q, c1_q;
	logic [15:0]   r1_q;
	logic          fe_q;
	logic          walk_last;

	assign wr_en     = accept & ~in_done_q;
	assign wr_addr   = AW'(AW'(in_ring_q) * AW'(MaxWidth)) + AW'(in_col_q);
	assign wr_data   = kind ? 8'd0 : pixel;   // pad inside the image reads as zero
	assign rd_en     = (state_q == lwsd_pkg::ST_ACC);
	assign rd_addr   = AW'(AW'(cur_ring_q) * AW'(MaxWidth)) + AW'(cur_col_q);
	assign walk_last = (cur_col_q == c1_q) && (cur_row_q == r1_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= store[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			cur_col_q  <= c0;
			c0_q       <= c0;
			c1_q       <= c1;
			cur_row_q  <= r0;
			r1_q       <= r1;
			cur_ring_q <= ring0;
			fe_q       <= fe;
		end else if (rd_en) begin
			if (cur_col_q == c1_q) begin
				cur_col_q  <= c0_q;
				cur_row_q  <= cur_row_q + 16'd1;
				cur_ring_q <= (cur_ring_q == RW'(Ring - 1)) ? '0 : cur_ring_q + RW'(1);
			end else begin
				cur_col_q <= cur_col_q + CW'(1);
			end
		end
	end

	// window sums
	logic [NW-1:0] n_q;
	logic [SW-1:0] s_q;
	logic [QW-1:0] s2_q;
	logic [15:0]   pix_sq;

	assign pix_sq = 16'(rd_data_s1) * 16'(rd_data_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			n_q         <= '0;
			s_q         <= '0;
			s2_q        <= '0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (accept && emit) begin
				n_q  <= '0;
				s_q  <= '0;
				s2_q <= '0;
			end else if (rd_valid_s1) begin
				n_q  <= n_q + NW'(1);
				s_q  <= s_q + SW'(rd_data_s1);
				s2_q <= s2_q + QW'(pix_sq);
			end
		end
	end

	// N*S2, S*S, N*N, then (N*S2 - S*S) / (N*N)
	logic [NumW-1:0] p1_q, p2_q;
	logic [DenW-1:0] den_q;
	logic            div_start;
	logic            div_busy;
	logic            div_done;
	logic [NumW-1:0] div_quot;

	always_ff @(posedge clk) begin
		if (state_q == lwsd_pkg::ST_MUL) begin
			p1_q  <= NumW'(n_q) * NumW'(s2_q);
			p2_q  <= NumW'(s_q) * NumW'(s_q);
			den_q <= DenW'(n_q) * DenW'(n_q);
		end
	end

	assign div_start = (state_q == lwsd_pkg::ST_DIV_GO);

	lwsd_divider #(
		.NumW(NumW),
		.DenW(DenW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(p1_q - p2_q),
		.divisor (den_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quot)
	);

	// square root chain, one root bit per cell
	lwsd_pkg::sqrt_bus_t chain [RtW+1];
	logic [RdW-1:0]      radicand;

	assign radicand = (|div_quot[NumW-1:RdW]) ? '1 : div_quot[RdW-1:0];
	assign chain[0] = '{valid: div_done, radicand: radicand, root: '0};

	for (genvar k = 0; k < RtW; k++) begin : g_root
		lwsd_sqrt_cell #(
			.Bit(RtW - 1 - k)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (chain[k]),
			.dout  (chain[k+1])
		);
	end

	logic [6:0] dev_q;

	always_ff @(posedge clk) begin
		if (chain[RtW].valid) begin
			dev_q <= (chain[RtW].root > RtW'(127)) ? 7'd127 : chain[RtW].root[6:0];
		end
	end

	// sequencer
	logic out_free;
	assign out_free = ~out_valid | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lwsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lwsd_pkg::ST_IDLE:   if (accept && emit) state_d = lwsd_pkg::ST_ACC;
			lwsd_pkg::ST_ACC:    if (walk_last) state_d = lwsd_pkg::ST_FLUSH;
			lwsd_pkg::ST_FLUSH:  state_d = lwsd_pkg::ST_MUL;
			lwsd_pkg::ST_MUL:    state_d = lwsd_pkg::ST_DIV_GO;
			lwsd_pkg::ST_DIV_GO: state_d = lwsd_pkg::ST_DIV;
			lwsd_pkg::ST_DIV:    if (div_done) state_d = lwsd_pkg::ST_ROOT;
			lwsd_pkg::ST_ROOT:   if (chain[RtW].valid) state_d = lwsd_pkg::ST_SEND;
			lwsd_pkg::ST_SEND:   if (out_free) state_d = lwsd_pkg::ST_IDLE;
			default:             state_d = lwsd_pkg::ST_IDLE;
		endcase
	end

	// output register: holds a result item while the next input item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == lwsd_pkg::ST_SEND && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lwsd_pkg::ST_SEND && out_free) begin
			deviation <= dev_q;
			frame_end <= fe_q;
		end
	end

	// checks
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_root_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		chain[RtW].valid |-> state_q == lwsd_pkg::ST_ROOT)
		else $error("square root result outside its state");

	a_pre_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pre_q <= delay)
		else $error("early-item count ran past the delay");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(WinArea))
		else $error("window pixel count above window area");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lwsd_pkg::ST_ACC |-> cur_row_q <= r1_q)
		else $error("window walk past its last row");

endmodule
`default_nettype wire

[rtl/lwsd_sqrt_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lwsd_sqrt_cell
// One cell of the square root chain: settles one root bit per cell.
// ----------------------------------------------------------------------------
module lwsd_sqrt_cell #(
	parameter int Bit = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lwsd_pkg::sqrt_bus_t din,
	output lwsd_pkg::sqrt_bus_t dout
);
	localparam int RW = lwsd_pkg::ROOT_W;
	localparam int QW = lwsd_pkg::RAD_W;
	localparam logic [RW-1:0] TrialBit = {{(RW-1){1'b0}}, 1'b1} << Bit;

	logic [RW-1:0]   trial;
	logic [2*RW-1:0] square;
	logic            valid_q;
	logic [QW-1:0]   radicand_q;
	logic [RW-1:0]   root_q;

	assign trial  = din.root | TrialBit;
	assign square = (2*RW)'(trial) * (2*RW)'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		radicand_q <= din.radicand;
		root_q     <= (QW'(square) <= din.radicand) ? trial : din.root;
	end

	assign dout = '{valid: valid_q, radicand: radicand_q, root: root_q};

endmodule
`default_nettype wire

[rtl/lwsd_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lwsd_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwsd_divider #(
	parameter int NumW = 24,
	parameter int DenW = 8
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire [NumW-1:0]  dividend,
	input  wire [DenW-1:0]  divisor,
	output logic            busy,
	output logic            done,
	output logic [NumW-1:0] quotient
);
	localparam int CntW = $clog2(NumW + 1);

	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NumW-1:0] quot_q;
	logic [DenW-1:0] den_q;
	logic [DenW:0]   rem_q;
	logic [DenW:0]   shifted;
	logic [DenW:0]   diff;
	logic            fits;

	assign shifted = {rem_q[DenW-1:0], quot_q[NumW-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CntW'(NumW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CntW'(1);
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff : shifted;
			quot_q <= {quot_q[NumW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quot_q;

endmodule
`default_nettype wire

[dv/local_window_std_deviation_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// local_window_std_deviation_test
// Self-checking bench: frames of random pixels under several window settings,
// results predicted by a local window model and compared in arrival order.
// ----------------------------------------------------------------------------
module local_window_std_deviation_test;

	localparam int MAX_W    = lwsd_pkg::MAX_WIDTH;
	localparam int MAX_H    = lwsd_pkg::MAX_HALF;
	localparam int RING     = 2 * MAX_H + 2;
	localparam int CYC_MAX  = 3000000;
	localparam int HOLD_LEN = 2000;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HALF_X = 2'd2;
	localparam logic [1:0] REG_HALF_Y = 2'd3;

	// item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_PAD   = 1'b1;

	typedef struct packed {
		logic [6:0] deviation;
		logic       frame_end;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [7:0]  pixel = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  deviation;
	logic        frame_end;

	local_window_std_deviation dut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [7:0]  line_ring [RING * MAX_W];
	int unsigned frame_pos;
	logic [10:0] reg_width  = 11'd1024;
	logic [15:0] reg_height = 16'd1;
	logic [2:0]  reg_half_x = 3'd1;
	logic [2:0]  reg_half_y = 3'd1;

	result_t     pending_results [$];
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          items_sent = 0;
	int          cycle_count = 0;

	function automatic int unsigned width_eff();
		if (reg_width == 0) return 1;
		if (reg_width > MAX_W) return MAX_W;
		return reg_width;
	endfunction

	function automatic int unsigned height_eff();
		return (reg_height == 0) ? 1 : reg_height;
	endfunction

	function automatic int unsigned half_eff(logic [2:0] h);
		return (h > MAX_H) ? MAX_H : h;
	endfunction

	function automatic logic [6:0] window_deviation(int qx, int qy, int w, int h,
			int hx, int hy);
		int r0, r1, c0, c1;
		longint unsigned n, s, s2, v, var_floor;
		int root;
		n = 0; s = 0; s2 = 0;
		r0 = (qy - hy < 0) ? 0 : qy - hy;
		r1 = (qy + hy > h - 1) ? h - 1 : qy + hy;
		c0 = (qx - hx < 0) ? 0 : qx - hx;
		c1 = (qx + hx > w - 1) ? w - 1 : qx + hx;
		for (int r = r0; r <= r1; r++)
			for (int c = c0; c <= c1; c++) begin
				v = line_ring[(r % RING) * MAX_W + c];
				n++; s += v; s2 += v * v;
			end
		var_floor = (n * s2 - s * s) / (n * n);
		root = 0;
		while (root < 127 && longint'(root + 1) * (root + 1) <= var_floor) root++;
		return root[6:0];
	endfunction

	// advance the window model by one accepted item
	task automatic predict_item(logic k, logic [7:0] px);
		int unsigned w, h, hx, hy, total, delay, q;
		result_t res;
		w = width_eff(); h = height_eff();
		hx = half_eff(reg_half_x); hy = half_eff(reg_half_y);
		total = w * h;
		delay = hx + hy * w;
		if (frame_pos < total)
			line_ring[((frame_pos / w) % RING) * MAX_W + frame_pos % w] =
				(k == KIND_PAD) ? 8'd0 : px;
		if (frame_pos < delay || frame_pos - delay >= total) begin
			frame_pos++;
			return;
		end
		q = frame_pos - delay;
		res.deviation = window_deviation(q % w, q / w, w, h, hx, hy);
		res.frame_end = (q == total - 1);
		pending_results.push_back(res);
		frame_pos = res.frame_end ? 0 : frame_pos + 1;
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// send one item; valid stays up until accepted, drops only on idle cycles
	task automatic send_item(logic k, logic [7:0] px);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		pixel    <= px;
		do @(posedge clk); while (!in_ready);
		predict_item(k, px);
		items_sent++;
	endtask

	task automatic write_register(logic [1:0] idx, logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_WIDTH:  reg_width  = val[10:0];
			REG_HEIGHT: reg_height = val;
			REG_HALF_X: reg_half_x = val[2:0];
			REG_HALF_Y: reg_half_y = val[2:0];
		endcase
		frame_pos = 0;
	endtask

	// stop sending, wait until every result is in, then the worst-case latency
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic configure(int w, int h, int hx, int hy);
		drain();
		write_register(REG_WIDTH, w[15:0]);
		write_register(REG_HEIGHT, h[15:0]);
		write_register(REG_HALF_X, hx[15:0]);
		write_register(REG_HALF_Y, hy[15:0]);
		cfg_write <= 1'b0;
	endtask

	function automatic int pad_count();
		return half_eff(reg_half_x) + half_eff(reg_half_y) * width_eff();
	endfunction

	// a whole frame of pixels plus its pad tail; mode 0 random, 1 extremes
	task automatic send_frame(int mode);
		int n;
		n = width_eff() * height_eff();
		for (int i = 0; i < n; i++)
			case (mode)
				1: send_item(KIND_PIXEL, (i % 2) ? 8'hFF : 8'h00);
				default: send_item(KIND_PIXEL, 8'($urandom));
			endcase
		for (int i = 0; i < pad_count(); i++) send_item(KIND_PAD, 8'($urandom));
	endtask

	task automatic test_directed();
		configure(3, 3, 1, 1);
		send_frame(1);
		// pad inside the image reads as zero; pixel after image acts as pad
		for (int i = 0; i < 9; i++)
			send_item((i == 4) ? KIND_PAD : KIND_PIXEL, 8'hFF - i[7:0]);
		for (int i = 0; i < pad_count(); i++) send_item(KIND_PIXEL, 8'hA5);
		// zero width and height taken as one, no delay
		configure(0, 0, 0, 0);
		send_item(KIND_PIXEL, 8'h80);
		send_item(KIND_PIXEL, 8'h7F);
	endtask

	task automatic test_settings();
		configure(5, 4, 7, 7);
		send_frame(0);
		configure(1, 6, 0, 2);
		send_frame(0);
		// oversized width taken as the maximum; frame cut short by the next write
		configure(2047, 1, 7, 0);
		for (int i = 0; i < 40; i++) send_item(KIND_PIXEL, 8'($urandom));
		configure(9, 3, 2, 1);
		send_frame(1);
	endtask

	task automatic test_random(int items);
		int start;
		start = items_sent;
		while (items_sent - start < items) begin
			configure($urandom_range(1, 12), $urandom_range(1, 8),
				$urandom_range(0, 7), $urandom_range(0, 7));
			if ($urandom_range(9) == 0) begin
				// broken frame: restarted by the next register write
				for (int i = $urandom_range(1, 20); i > 0; i--)
					send_item(1'($urandom), 8'($urandom));
			end else
				send_frame(0);
		end
	endtask

	// receiver holds off while sender keeps offering, then sender waits out
	task automatic test_backpressure();
		configure(16, 6, 3, 2);
		hold_requests++;
		send_frame(0);
		drain();
		send_frame(0);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		frame_pos = 0;
		test_directed();
		test_settings();
		test_backpressure();
		send_idle_pct = 0;  recv_stall_pct = 0;  test_random(240);
		send_idle_pct = 53; recv_stall_pct = 0;  test_random(240);
		send_idle_pct = 0;  recv_stall_pct = 53; test_random(240);
		send_idle_pct = 30; recv_stall_pct = 30; test_random(240);
		drain();
		if (error_count == 0)
			$display("** local_window_std_deviation: PASSED **");
		else
			$display("** local_window_std_deviation: FAILED **");
		$finish;
	end

	// receiver readiness, with a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_LEN - 1;
			out_ready   <= 1'b0;
		end else
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	// result checker: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0)
				report_mismatch("result with nothing expected");
			else begin
				exp_res = pending_results.pop_front();
				if (deviation !== exp_res.deviation)
					report_mismatch($sformatf("deviation %0d, expected %0d",
						deviation, exp_res.deviation));
				if (frame_end !== exp_res.frame_end)
					report_mismatch($sformatf("frame_end %0b, expected %0b",
						frame_end, exp_res.frame_end));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYC_MAX) begin
			$display("** local_window_std_deviation: FAILED **");
			$finish;
		end
	end

endmodule
